[design/lcrpd_pkg.sv]
`default_nettype none

package lcrpd_pkg;

    // sizes of the readout and the averaging
    localparam int AVG_COUNT = 10;
    localparam int DATA_BITS = 24;

    localparam int THR_W   = 24;
    localparam int HP_W    = 8;
    localparam int SUM_W   = 28;
    localparam int CFG_W   = 24;
    localparam int LIMIT_W = THR_W + $clog2(AVG_COUNT + 1);
    localparam int CMP_W   = (LIMIT_W > SUM_W) ? LIMIT_W : SUM_W;
    localparam int PULSE_W = $clog2(DATA_BITS + 1);
    localparam int GRP_W   = $clog2(AVG_COUNT + 1);

    // configuration register indexes
    localparam logic REG_DETECT_THRESHOLD  = 1'b0;
    localparam logic REG_HALF_PERIOD_TICKS = 1'b1;

    // reset values of the configuration registers
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5000);
    localparam logic [HP_W-1:0]  HALF_RESET      = HP_W'(2);

    localparam logic [DATA_BITS-1:0] WORD_TOP = {1'b1, {(DATA_BITS - 1){1'b0}}};
    localparam logic [SUM_W-1:0]     SUM_MAX  = {SUM_W{1'b1}};

    // reading event from the pin sequencer to the group logic
    typedef struct packed {
        logic                 rvalid;
        logic [DATA_BITS-1:0] shift_next;
    } seq_evt_t;

    // saturating add of a reading to a running sum
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [DATA_BITS-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/lcrpd_seq.sv]
`default_nettype none

module lcrpd_seq
    import lcrpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 data_level,
    input  wire logic [HP_W-1:0]      half_ticks,
    output logic                      clock_level,
    output logic [DATA_BITS-1:0]      reading_next,
    output seq_evt_t                  evt
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_DHIGH = 3'd2;
    localparam logic [2:0] PH_DLOW  = 3'd3;
    localparam logic [2:0] PH_GHIGH = 3'd4;
    localparam logic [2:0] PH_GLOW  = 3'd5;

    logic [2:0]           phase_reg, phase_next;
    logic [HP_W-1:0]      tick_reg, tick_next;
    logic [PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [DATA_BITS-1:0] reading_reg;
    logic [HP_W-1:0]      hp;
    logic [HP_W-1:0]      tick_inc;
    logic [PULSE_W-1:0]   pulse_inc;
    logic                 rvalid;

    // a half period of zero counts as one
    assign hp        = (half_ticks == '0) ? HP_W'(1) : half_ticks;
    assign tick_inc  = tick_reg + HP_W'(1);
    assign pulse_inc = pulse_reg + PULSE_W'(1);

    assign clock_level = (phase_reg == PH_DHIGH) || (phase_reg == PH_GHIGH);

    // pin phase sequencing for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pulse_next = pulse_reg;
        shift_next = shift_reg;
        rvalid     = 1'b0;
        if (phase_reg == PH_WAIT)
        begin
            if (!data_level)
            begin
                phase_next = PH_DHIGH;
                tick_next  = '0;
                pulse_next = '0;
                shift_next = '0;
            end
        end
        else if (tick_inc >= hp)
        begin
            tick_next = '0;
            case (phase_reg)
                PH_IDLE:  phase_next = PH_WAIT;
                PH_DHIGH: phase_next = PH_DLOW;
                PH_DLOW:
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], data_level};
                    pulse_next = pulse_inc;
                    phase_next = (pulse_inc >= PULSE_W'(DATA_BITS)) ? PH_GHIGH : PH_DHIGH;
                end
                PH_GHIGH: phase_next = PH_GLOW;
                default:
                begin
                    phase_next = PH_IDLE;
                    rvalid     = 1'b1;
                end
            endcase
        end
        else
        begin
            tick_next = tick_inc;
        end
    end

    assign reading_next   = rvalid ? (shift_reg ^ WORD_TOP) : reading_reg;
    assign evt.rvalid     = rvalid;
    assign evt.shift_next = shift_next;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            pulse_reg   <= '0;
            shift_reg   <= '0;
            reading_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            pulse_reg   <= pulse_next;
            shift_reg   <= shift_next;
            reading_reg <= reading_next;
        end
    end

endmodule

`default_nettype wire

[design/lcrpd_grp.sv]
`default_nettype none

module lcrpd_grp
    import lcrpd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               command,
    input  wire logic [LIMIT_W-1:0] limit,
    input  wire seq_evt_t           evt,
    output logic                    group_valid,
    output logic [SUM_W-1:0]        sum_next,
    output logic                    item_next,
    output logic                    base_valid_next
);

    logic [SUM_W-1:0] run_reg, run_next;
    logic [SUM_W-1:0] cand_reg, cand_next;
    logic [SUM_W-1:0] base_reg, base_next;
    logic [SUM_W-1:0] held_sum_reg;
    logic [GRP_W-1:0] gc_reg, gc_next;
    logic [GRP_W-1:0] gc_inc;
    logic             base_valid_reg;
    logic             pend_reg, pend_next;
    logic             item_reg;
    logic             pend_eff;
    logic [SUM_W-1:0] diff;

    assign pend_eff = pend_reg | command;
    assign gc_inc   = gc_reg + GRP_W'(1);
    // cand_reg already holds the running sum plus the word in flight
    assign diff     = (cand_reg >= base_reg) ? (cand_reg - base_reg) : (base_reg - cand_reg);

    // group accumulation, baseline capture and comparison
    always_comb
    begin
        run_next        = run_reg;
        gc_next         = gc_reg;
        base_next       = base_reg;
        base_valid_next = base_valid_reg;
        pend_next       = pend_eff;
        sum_next        = held_sum_reg;
        item_next       = item_reg;
        group_valid     = 1'b0;
        if (evt.rvalid)
        begin
            if (gc_inc >= GRP_W'(AVG_COUNT))
            begin
                group_valid = 1'b1;
                sum_next    = cand_reg;
                run_next    = '0;
                gc_next     = '0;
                if (!base_valid_reg || pend_eff)
                begin
                    base_next       = cand_reg;
                    base_valid_next = 1'b1;
                    pend_next       = 1'b0;
                    item_next       = 1'b0;
                end
                else
                begin
                    item_next = CMP_W'(diff) > CMP_W'(limit);
                end
            end
            else
            begin
                run_next = cand_reg;
                gc_next  = gc_inc;
            end
        end
    end

    // precomputed sum for the next reading
    assign cand_next = sat_add(run_next, evt.shift_next ^ WORD_TOP);

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= '0;
            cand_reg       <= SUM_W'(WORD_TOP);
            base_reg       <= '0;
            held_sum_reg   <= '0;
            gc_reg         <= '0;
            base_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
            item_reg       <= 1'b0;
        end
        else if (step)
        begin
            run_reg        <= run_next;
            cand_reg       <= cand_next;
            base_reg       <= base_next;
            held_sum_reg   <= sum_next;
            gc_reg         <= gc_next;
            base_valid_reg <= base_valid_next;
            pend_reg       <= pend_next;
            item_reg       <= item_next;
        end
    end

endmodule

`default_nettype wire

[design/load_cell_readout_presence_detector_top.sv]
// channel  handshake               payload
// in       in_valid / in_ready     data_level, command
// out      out_valid / out_ready   clock_level, reading_valid, reading, group_valid,
//                                  reading_sum, item_detected, baseline_ready
// cfg      cfg_write               cfg_index, cfg_data
//
// one transaction in and one out per cycle while the output is not stalled;
// each input tick is held in the input register, and its result is then
// registered in the output register. the output register frees on out_ready,
// so an output stall backs up into the input register and then drops in_ready.
// reset clears the sequencer to idle low and run, base and held sums and flags to zero.
`default_nettype none

module load_cell_readout_presence_detector_top
    import lcrpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 data_level,
    input  wire logic                 command,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      clock_level,
    output logic                      reading_valid,
    output logic [DATA_BITS-1:0]      reading,
    output logic                      group_valid,
    output logic [SUM_W-1:0]          reading_sum,
    output logic                      item_detected,
    output logic                      baseline_ready,
    input  wire logic                 cfg_write,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic                 inq_valid_reg;
    logic                 data_reg;
    logic                 cmd_reg;
    logic                 out_valid_reg;
    logic                 step;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [HP_W-1:0]      half_reg;

    logic                 clk_lvl;
    logic [DATA_BITS-1:0] reading_nx;
    seq_evt_t             evt;
    logic                 gvalid;
    logic [SUM_W-1:0]     sum_nx;
    logic                 item_nx;
    logic                 bvalid_nx;

    logic                 clock_level_reg;
    logic                 reading_valid_reg;
    logic [DATA_BITS-1:0] reading_reg;
    logic                 group_valid_reg;
    logic [SUM_W-1:0]     reading_sum_reg;
    logic                 item_detected_reg;
    logic                 baseline_ready_reg;

    // a tick advances when the output register is free or being drained
    assign step     = inq_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !inq_valid_reg || step;

    // configuration registers, threshold kept scaled by the group size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(THRESHOLD_RESET * LIMIT_W'(AVG_COUNT));
            half_reg  <= HALF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DETECT_THRESHOLD:  limit_reg <= cfg_data[THR_W-1:0] * LIMIT_W'(AVG_COUNT);
                REG_HALF_PERIOD_TICKS: half_reg  <= cfg_data[HP_W-1:0];
                default:               half_reg  <= half_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            inq_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            inq_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_level;
            cmd_reg  <= command;
        end
    end

    lcrpd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_level   (data_reg),
        .half_ticks   (half_reg),
        .clock_level  (clk_lvl),
        .reading_next (reading_nx),
        .evt          (evt)
    );

    lcrpd_grp u_grp (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .command         (cmd_reg),
        .limit           (limit_reg),
        .evt             (evt),
        .group_valid     (gvalid),
        .sum_next        (sum_nx),
        .item_next       (item_nx),
        .base_valid_next (bvalid_nx)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            clock_level_reg    <= clk_lvl;
            reading_valid_reg  <= evt.rvalid;
            reading_reg        <= reading_nx;
            group_valid_reg    <= gvalid;
            reading_sum_reg    <= sum_nx;
            item_detected_reg  <= item_nx;
            baseline_ready_reg <= bvalid_nx;
        end
    end

    assign out_valid      = out_valid_reg;
    assign clock_level    = clock_level_reg;
    assign reading_valid  = reading_valid_reg;
    assign reading        = reading_reg;
    assign group_valid    = group_valid_reg;
    assign reading_sum    = reading_sum_reg;
    assign item_detected  = item_detected_reg;
    assign baseline_ready = baseline_ready_reg;

endmodule

`default_nettype wire

[dv/tb_load_cell_readout_presence_detector_top.sv]
`default_nettype none

module tb_load_cell_readout_presence_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcrpd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 21;
    localparam int MAX_REPORTS = 100;

    // threshold used by the directed comparisons
    localparam logic [DATA_BITS-1:0] STEP      = 24'd1000;

    // pin sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_DHIGH,
        PH_DLOW,
        PH_GHIGH,
        PH_GLOW
    } pin_phase_e;

    // one output transaction
    typedef struct packed {
        logic                 clk_lvl;
        logic                 rd_valid;
        logic [DATA_BITS-1:0] rd;
        logic                 grp_valid;
        logic [SUM_W-1:0]     grp_sum;
        logic                 detected;
        logic                 base_ok;
    } readout_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             data_level = 1'b0;
    logic             command   = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             clock_level;
    logic             reading_valid;
    logic [DATA_BITS-1:0] reading;
    logic             group_valid;
    logic [SUM_W-1:0] reading_sum;
    logic             item_detected;
    logic             baseline_ready;
    logic             cfg_write = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // predicted block state
    pin_phase_e           ph         = PH_IDLE;
    logic [7:0]           tick_cnt   = '0;
    int unsigned          pulse_cnt  = 0;
    logic [DATA_BITS-1:0] shift_reg  = '0;
    int unsigned          grp_cnt    = 0;
    logic [SUM_W-1:0]     acc_sum    = '0;
    logic [SUM_W-1:0]     base_sum   = '0;
    logic                 base_ok    = 1'b0;
    logic                 rebase_req = 1'b0;
    logic [DATA_BITS-1:0] held_rd    = '0;
    logic [SUM_W-1:0]     held_sum   = '0;
    logic                 held_det   = 1'b0;
    logic [THR_W-1:0]     thr_cfg    = THRESHOLD_RESET;
    logic [HP_W-1:0]      hp_cfg     = HALF_RESET;
    bit                   last_rd_valid = 1'b0;

    readout_t    pending_readouts[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          stalls_on      = 1'b1;
    int unsigned rebase_rate    = 0;

    load_cell_readout_presence_detector_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_level     (data_level),
        .command        (command),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .clock_level    (clock_level),
        .reading_valid  (reading_valid),
        .reading        (reading),
        .group_valid    (group_valid),
        .reading_sum    (reading_sum),
        .item_detected  (item_detected),
        .baseline_ready (baseline_ready),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] eff_half();
        return (hp_cfg == '0) ? 8'd1 : hp_cfg;
    endfunction

    function automatic logic [SUM_W-1:0] sum_clamp(input logic [SUM_W-1:0] acc,
                                                   input logic [DATA_BITS-1:0] word);
        logic [SUM_W:0] total;
        total = {1'b0, acc} + {{(SUM_W + 1 - DATA_BITS){1'b0}}, word};
        return (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    // advance the predicted sequencer and group logic by one tick
    task automatic step_readout(input logic d, input logic c);
        readout_t         r;
        logic [SUM_W-1:0] diff;
        logic [63:0]      limit;
        r = '0;
        r.clk_lvl = (ph == PH_DHIGH || ph == PH_GHIGH);
        if (c)
            rebase_req = 1'b1;

        // pin sequencer
        if (ph == PH_WAIT)
        begin
            if (!d)
            begin
                ph        = PH_DHIGH;
                tick_cnt  = '0;
                pulse_cnt = 0;
                shift_reg = '0;
            end
        end
        else
        begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= eff_half())
            begin
                tick_cnt = '0;
                case (ph)
                    PH_IDLE:  ph = PH_WAIT;
                    PH_DHIGH: ph = PH_DLOW;
                    PH_DLOW:
                    begin
                        shift_reg = {shift_reg[DATA_BITS-2:0], d};
                        pulse_cnt++;
                        if (pulse_cnt >= DATA_BITS)
                            ph = PH_GHIGH;
                        else
                            ph = PH_DHIGH;
                    end
                    PH_GHIGH: ph = PH_GLOW;
                    default:
                    begin
                        ph         = PH_IDLE;
                        r.rd_valid = 1'b1;
                        held_rd    = shift_reg ^ WORD_TOP;
                    end
                endcase
            end
        end

        // averaging and presence decision
        if (r.rd_valid)
        begin
            acc_sum = sum_clamp(acc_sum, held_rd);
            grp_cnt++;
            if (grp_cnt >= AVG_COUNT)
            begin
                r.grp_valid = 1'b1;
                held_sum    = acc_sum;
                acc_sum     = '0;
                grp_cnt     = 0;
                if (!base_ok || rebase_req)
                begin
                    base_sum   = held_sum;
                    base_ok    = 1'b1;
                    rebase_req = 1'b0;
                    held_det   = 1'b0;
                end
                else
                begin
                    diff     = (held_sum >= base_sum) ? held_sum - base_sum
                                                      : base_sum - held_sum;
                    limit    = 64'(thr_cfg) * 64'(AVG_COUNT);
                    held_det = (64'(diff) > limit);
                end
            end
        end

        r.rd       = held_rd;
        r.grp_sum  = held_sum;
        r.detected = held_det;
        r.base_ok  = base_ok;
        last_rd_valid = r.rd_valid;
        pending_readouts.push_back(r);
    endtask

    // data pin as the converter would drive it for the given word
    function automatic logic pin_level(input logic [DATA_BITS-1:0] word);
        if (ph == PH_WAIT)
            return ($urandom_range(99) < 70) ? 1'b0 : 1'b1;
        if (ph == PH_DLOW && 32'(tick_cnt) + 1 >= 32'(eff_half()))
            return word[DATA_BITS - 1 - pulse_cnt];
        return 1'($urandom_range(1));
    endfunction

    // one input transaction, then an optional idle gap
    task automatic send_tick(input logic d, input logic c);
        in_valid   <= 1'b1;
        data_level <= d;
        command    <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_readout(d, c);
        if (stalls_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid   <= 1'b0;
                data_level <= 1'($urandom_range(1));
                command    <= 1'($urandom_range(1));
                @(posedge clk);
            end
        end
    endtask

    // stop sending and let every expected transaction come out
    task automatic drain_readouts();
        in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        drain_readouts();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_DETECT_THRESHOLD)
            thr_cfg = value[THR_W-1:0];
        else
            hp_cfg = value[HP_W-1:0];
    endtask

    // ticks until one reading completes; optional rebaseline on its last tick
    task automatic read_word(input logic [DATA_BITS-1:0] word, input bit rebase_at_end);
        logic d;
        logic c;
        do
        begin
            d = pin_level(word);
            c = (rebase_at_end && ph == PH_GLOW && 32'(tick_cnt) + 1 >= 32'(eff_half()))
                || ($urandom_range(999) < rebase_rate);
            send_tick(d, c);
        end
        while (!last_rd_valid);
    endtask

    // one group whose readings add up to the given sum
    task automatic read_group_sum(input logic [SUM_W-1:0] target, input bit rebase);
        logic [SUM_W-1:0]     share;
        logic [DATA_BITS-1:0] rd;
        share = target / SUM_W'(AVG_COUNT);
        for (int i = 0; i < AVG_COUNT; i++)
        begin
            if (i == AVG_COUNT - 1)
                rd = DATA_BITS'(target - share * SUM_W'(AVG_COUNT - 1));
            else
                rd = DATA_BITS'(share);
            read_word(rd ^ WORD_TOP, rebase && i == AVG_COUNT - 1);
        end
    endtask

    // extreme words, the first at reset settings; the first group is the baseline
    task automatic test_word_extremes();
        logic [DATA_BITS-1:0] words [AVG_COUNT];
        words = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hAAAAAA,
                  24'h555555, 24'h000001, 24'hFFFFFE, 24'h7FFFFE, 24'h800001};
        read_word(words[0], 1'b0);
        // upper bits of the write are dropped, leaving a half period of one
        write_reg(REG_HALF_PERIOD_TICKS, CFG_W'(24'hFFFF01));
        for (int i = 1; i < AVG_COUNT; i++)
            read_word(words[i], 1'b0);
    endtask

    // group just past the threshold above the baseline, with no idling at all
    task automatic test_threshold_up();
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(STEP));
        stalls_on = 1'b0;
        read_group_sum(base_sum + SUM_W'(STEP) * SUM_W'(AVG_COUNT) + SUM_W'(1), 1'b0);
        stalls_on = 1'b1;
    endtask

    // group exactly at the threshold below the baseline is not flagged
    task automatic test_threshold_down();
        read_group_sum(base_sum - SUM_W'(STEP) * SUM_W'(AVG_COUNT), 1'b0);
    endtask

    // rebaseline on the completing tick of a group, zero half period
    task automatic test_rebaseline();
        write_reg(REG_HALF_PERIOD_TICKS, CFG_W'(0));
        rebase_rate = 2;
        read_group_sum(SUM_W'($urandom_range(32'd167772150)), 1'b1);
        rebase_rate = 0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin : check_readouts
        readout_t got;
        readout_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {clock_level, reading_valid, reading, group_valid, reading_sum,
                   item_detected, baseline_ready};
            if (pending_readouts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t unexpected transaction: expected none, actual %h",
                             $time, got);
            end
            else
            begin
                want = pending_readouts.pop_front();
                check_field("clock_level", want.clk_lvl, got.clk_lvl);
                check_field("reading_valid", want.rd_valid, got.rd_valid);
                check_field("reading", want.rd, got.rd);
                check_field("group_valid", want.grp_valid, got.grp_valid);
                check_field("reading_sum", want.grp_sum, got.grp_sum);
                check_field("item_detected", want.detected, got.detected);
                check_field("baseline_ready", want.base_ok, got.base_ok);
            end
        end
        out_ready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_word_extremes();
        test_threshold_up();
        test_threshold_down();
        test_rebaseline();
        drain_readouts();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_readouts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
